FILE: rtl/rgcg_pkg.sv
// ----------------------------------------------------------------------------
// rgcg_pkg
// Shared constants and types for the rainbow grid color generator.
// ----------------------------------------------------------------------------
package rgcg_pkg;

    // Grid geometry.
    localparam int GRID_SIZE = 8;
    localparam int COORD_W   = 3;

    // Fixed-point widths: phase Q3.16, hue Q0.16, levels Q1.16.
    localparam int PHASE_W  = 19;
    localparam int HUE_W    = 16;
    localparam int LEVEL_W  = 17;
    localparam int SPEED_W  = 16;
    localparam int BRIGHT_W = 9;
    localparam int DT_W     = 16;
    localparam int DYN_W    = 10;
    localparam int ESPEED_W = 27;
    localparam int CH_W     = 6;

    // Register port.
    localparam int REG_INDEX_W = 1;
    localparam int REG_DATA_W  = 16;
    localparam logic [REG_INDEX_W-1:0] REG_SPEED_GAIN = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_BRIGHTNESS = 1'b1;

    // Operation codes.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Reset values of the registers.
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd4096;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd256;

    // Arithmetic constants.
    localparam logic [PHASE_W-1:0] TWO_PI_Q16   = 19'd411774;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE    = 17'd65536;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR  = 17'd13107;
    localparam logic [15:0]        EIGHT_TENTHS = 16'd52429;
    localparam logic [10:0]        SPEED_UNITY  = 11'd256;
    localparam logic [CH_W-1:0]    CH_MAX       = 6'd63;
    localparam int                 DIAG_SHIFT   = 13;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Write side of the queue.
    typedef struct packed {
        logic             valid;
        logic [HUE_W-1:0] hue;
    } q_wr_t;

    // Read side of the queue.
    typedef struct packed {
        logic             valid;
        logic [HUE_W-1:0] hue;
    } q_rd_t;

endpackage

FILE: rtl/rgcg_front.sv
// ----------------------------------------------------------------------------
// rgcg_front
// Accepts input words, advances the phase on ticks and computes the base
// hue of each render frame in two multiply stages.
// ----------------------------------------------------------------------------
module rgcg_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [rgcg_pkg::DT_W-1:0]      delta_time,
    input  logic [rgcg_pkg::DYN_W-1:0]     dynamic_factor,
    input  logic [rgcg_pkg::SPEED_W-1:0]   speed_gain,
    input  logic                           q_full,
    output rgcg_pkg::q_wr_t                q_wr,
    output logic [rgcg_pkg::PHASE_W-1:0]   phase
);

    logic [rgcg_pkg::PHASE_W-1:0]  phase_reg;
    logic [rgcg_pkg::PHASE_W-1:0]  phase_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [rgcg_pkg::ESPEED_W-1:0] s1_espeed_reg;
    logic [rgcg_pkg::PHASE_W-1:0]  s1_phase_reg;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic [rgcg_pkg::HUE_W-1:0]    s2_hue_reg;
    logic                          adv;
    logic                          accept;
    logic [rgcg_pkg::PHASE_W:0]    phase_sum;
    logic [rgcg_pkg::PHASE_W-1:0]  phase_wrap;
    logic [rgcg_pkg::ESPEED_W-1:0] espeed;
    logic [45:0]                   hue_prod;

    // The pipeline moves unless a finished frame waits on a full queue.
    assign adv      = !s2_valid_reg || !q_full;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // Phase accumulator with a single wrap past two pi.
    always_comb
    begin
        phase_sum  = {1'b0, phase_reg} + (rgcg_pkg::PHASE_W + 1)'(delta_time);
        phase_wrap = phase_sum[rgcg_pkg::PHASE_W-1:0];
        phase_next = phase_reg;
        if (accept && op == rgcg_pkg::OP_TICK)
        begin
            if (phase_wrap > rgcg_pkg::TWO_PI_Q16)
            begin
                phase_next = phase_wrap - rgcg_pkg::TWO_PI_Q16;
            end
            else
            begin
                phase_next = phase_wrap;
            end
        end
    end

    // Effective speed, Q7.20, and the hue fraction from its product with the phase.
    assign espeed   = rgcg_pkg::ESPEED_W'(speed_gain)
                    * rgcg_pkg::ESPEED_W'(rgcg_pkg::SPEED_UNITY + 11'(dynamic_factor));
    assign hue_prod = 46'(s1_phase_reg) * 46'(s1_espeed_reg);

    // Stage valid bits.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (adv)
        begin
            s1_valid_next = accept && op == rgcg_pkg::OP_RENDER;
            s2_valid_next = s1_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_espeed_reg <= espeed;
            s1_phase_reg  <= phase_reg;
            s2_hue_reg    <= hue_prod[35:20];
        end
    end

    assign q_wr.valid = s2_valid_reg && !q_full;
    assign q_wr.hue   = s2_hue_reg;
    assign phase      = phase_reg;

endmodule

FILE: rtl/rgcg_queue.sv
// ----------------------------------------------------------------------------
// rgcg_queue
// Two-entry queue of frame base hues between the front and back parts.
// ----------------------------------------------------------------------------
module rgcg_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  rgcg_pkg::q_wr_t q_wr,
    input  logic            pop,
    output rgcg_pkg::q_rd_t q_rd,
    output logic            q_full
);

    logic [rgcg_pkg::HUE_W-1:0]  entry_reg [rgcg_pkg::QUEUE_DEPTH];
    logic [rgcg_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rgcg_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [rgcg_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rgcg_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [rgcg_pkg::QCNT_W-1:0] count_reg;
    logic [rgcg_pkg::QCNT_W-1:0] count_next;
    logic                        do_pop;

    assign do_pop = pop && count_reg != '0;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.valid)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_wr.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !q_wr.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (q_wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.hue;
        end
    end

    assign q_full     = count_reg == rgcg_pkg::QCNT_W'(rgcg_pkg::QUEUE_DEPTH);
    assign q_rd.valid = count_reg != '0;
    assign q_rd.hue   = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/rgcg_back.sv
// ----------------------------------------------------------------------------
// rgcg_back
// Walks the grid for each queued frame and turns every pixel's hue into
// three saturated 6-bit channels through a four-stage pipeline.
// ----------------------------------------------------------------------------
module rgcg_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgcg_pkg::q_rd_t               q_rd,
    output logic                          pop,
    input  logic [rgcg_pkg::BRIGHT_W-1:0] brightness_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rgcg_pkg::COORD_W-1:0]  pixel_x,
    output logic [rgcg_pkg::COORD_W-1:0]  pixel_y,
    output logic [rgcg_pkg::CH_W-1:0]     red,
    output logic [rgcg_pkg::CH_W-1:0]     green,
    output logic [rgcg_pkg::CH_W-1:0]     blue,
    output logic                          frame_last
);

    // Hue sectors.
    localparam logic [2:0] SEC_BLUE_FADE  = 3'd0;
    localparam logic [2:0] SEC_RED_FADE   = 3'd1;
    localparam logic [2:0] SEC_BLUE_RISE  = 3'd2;
    localparam logic [2:0] SEC_RED_DROP   = 3'd3;
    localparam logic [2:0] SEC_GREEN_RISE = 3'd4;

    localparam int PROD_W = rgcg_pkg::BRIGHT_W + rgcg_pkg::LEVEL_W;
    localparam int SCALE_W = 32;

    localparam logic [rgcg_pkg::COORD_W-1:0] COORD_MAX =
        rgcg_pkg::COORD_W'(rgcg_pkg::GRID_SIZE - 1);

    // Pixel sequencer.
    logic                         busy_reg;
    logic                         busy_next;
    logic [rgcg_pkg::COORD_W-1:0] x_reg;
    logic [rgcg_pkg::COORD_W-1:0] x_next;
    logic [rgcg_pkg::COORD_W-1:0] y_reg;
    logic [rgcg_pkg::COORD_W-1:0] y_next;
    logic [rgcg_pkg::HUE_W-1:0]   base_reg;
    logic                         adv;
    logic                         issue;
    logic                         last_pix;
    logic [rgcg_pkg::COORD_W:0]   diag;
    logic [rgcg_pkg::HUE_W-1:0]   hue_gen;

    // Stage A: pixel hue.
    logic                         a_valid_reg;
    logic [rgcg_pkg::COORD_W-1:0] a_x_reg;
    logic [rgcg_pkg::COORD_W-1:0] a_y_reg;
    logic                         a_last_reg;
    logic [rgcg_pkg::HUE_W-1:0]   a_hue_reg;

    // Stage B: sector, fraction and fade product.
    logic                         b_valid_reg;
    logic [rgcg_pkg::COORD_W-1:0] b_x_reg;
    logic [rgcg_pkg::COORD_W-1:0] b_y_reg;
    logic                         b_last_reg;
    logic [2:0]                   b_sector_reg;
    logic [rgcg_pkg::HUE_W-1:0]   b_frac_reg;
    logic [rgcg_pkg::LEVEL_W-1:0] b_fprod_reg;
    logic [rgcg_pkg::HUE_W+2:0]   h6;
    logic [2:0]                   sector;
    logic [rgcg_pkg::HUE_W-1:0]   frac;
    logic [rgcg_pkg::LEVEL_W-1:0] fade_arg;
    logic [32:0]                  fade_prod;

    // Stage C: brightness products.
    logic                         c_valid_reg;
    logic [rgcg_pkg::COORD_W-1:0] c_x_reg;
    logic [rgcg_pkg::COORD_W-1:0] c_y_reg;
    logic                         c_last_reg;
    logic [PROD_W-1:0]            c_r_reg;
    logic [PROD_W-1:0]            c_g_reg;
    logic [PROD_W-1:0]            c_b_reg;
    logic [rgcg_pkg::LEVEL_W-1:0] fade_lvl;
    logic [rgcg_pkg::LEVEL_W-1:0] frac_lvl;
    logic [rgcg_pkg::LEVEL_W-1:0] lvl_r;
    logic [rgcg_pkg::LEVEL_W-1:0] lvl_g;
    logic [rgcg_pkg::LEVEL_W-1:0] lvl_b;

    // Output register.
    logic                         out_valid_reg;
    logic [rgcg_pkg::COORD_W-1:0] out_x_reg;
    logic [rgcg_pkg::COORD_W-1:0] out_y_reg;
    logic                         out_last_reg;
    logic [rgcg_pkg::CH_W-1:0]    out_r_reg;
    logic [rgcg_pkg::CH_W-1:0]    out_g_reg;
    logic [rgcg_pkg::CH_W-1:0]    out_b_reg;
    logic [rgcg_pkg::CH_W-1:0]    ch_r;
    logic [rgcg_pkg::CH_W-1:0]    ch_g;
    logic [rgcg_pkg::CH_W-1:0]    ch_b;

    // Scale a brightness product by 63 / 2^24 and saturate.
    function automatic logic [rgcg_pkg::CH_W-1:0] scale_channel(input logic [PROD_W-1:0] p);
        logic [SCALE_W-1:0] v;
        logic [7:0]         top;
        v   = (SCALE_W'(p) << 6) - SCALE_W'(p);
        top = v[SCALE_W-1:24];
        if (top > 8'(rgcg_pkg::CH_MAX))
        begin
            return rgcg_pkg::CH_MAX;
        end
        return top[rgcg_pkg::CH_W-1:0];
    endfunction

    // The whole pipeline moves when the output register is free or being taken.
    assign adv      = !out_valid_reg || !out_stall;
    assign pop      = !busy_reg && q_rd.valid;
    assign issue    = busy_reg && adv;
    assign last_pix = x_reg == COORD_MAX && y_reg == COORD_MAX;

    // Raster scan, row by row.
    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            x_next    = '0;
            y_next    = '0;
        end
        else if (issue)
        begin
            if (last_pix)
            begin
                busy_next = 1'b0;
            end
            if (x_reg == COORD_MAX)
            begin
                x_next = '0;
                y_next = y_reg + 1'b1;
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    // Diagonal offset of one eighth per step of x plus y.
    assign diag    = (rgcg_pkg::COORD_W + 1)'(x_reg) + (rgcg_pkg::COORD_W + 1)'(y_reg);
    assign hue_gen = base_reg + rgcg_pkg::HUE_W'(32'(diag) << rgcg_pkg::DIAG_SHIFT);

    // Sector split and the 0.8 fade multiply.
    always_comb
    begin
        h6     = (rgcg_pkg::HUE_W + 3)'(a_hue_reg) * (rgcg_pkg::HUE_W + 3)'(6);
        sector = h6[rgcg_pkg::HUE_W+2:rgcg_pkg::HUE_W];
        frac   = h6[rgcg_pkg::HUE_W-1:0];
        if (sector == SEC_RED_FADE)
        begin
            fade_arg = rgcg_pkg::LEVEL_ONE - rgcg_pkg::LEVEL_W'(frac);
        end
        else
        begin
            fade_arg = rgcg_pkg::LEVEL_W'(frac);
        end
        fade_prod = 33'(rgcg_pkg::EIGHT_TENTHS) * 33'(fade_arg);
    end

    // Channel levels per sector.
    always_comb
    begin
        fade_lvl = rgcg_pkg::LEVEL_ONE - b_fprod_reg;
        frac_lvl = rgcg_pkg::LEVEL_W'(b_frac_reg);
        case (b_sector_reg)
            SEC_BLUE_FADE:
            begin
                lvl_r = rgcg_pkg::LEVEL_ONE;
                lvl_g = rgcg_pkg::LEVEL_FLOOR;
                lvl_b = fade_lvl;
            end
            SEC_RED_FADE:
            begin
                lvl_r = fade_lvl;
                lvl_g = rgcg_pkg::LEVEL_ONE;
                lvl_b = rgcg_pkg::LEVEL_FLOOR;
            end
            SEC_BLUE_RISE:
            begin
                lvl_r = rgcg_pkg::LEVEL_FLOOR;
                lvl_g = rgcg_pkg::LEVEL_ONE;
                lvl_b = frac_lvl;
            end
            SEC_RED_DROP:
            begin
                lvl_r = fade_lvl;
                lvl_g = rgcg_pkg::LEVEL_ONE;
                lvl_b = rgcg_pkg::LEVEL_FLOOR;
            end
            SEC_GREEN_RISE:
            begin
                lvl_r = rgcg_pkg::LEVEL_FLOOR;
                lvl_g = frac_lvl;
                lvl_b = rgcg_pkg::LEVEL_ONE;
            end
            default:
            begin
                lvl_r = rgcg_pkg::LEVEL_ONE;
                lvl_g = rgcg_pkg::LEVEL_FLOOR;
                lvl_b = rgcg_pkg::LEVEL_ONE;
            end
        endcase
    end

    // Final scaling.
    assign ch_r = scale_channel(c_r_reg);
    assign ch_g = scale_channel(c_g_reg);
    assign ch_b = scale_channel(c_b_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            if (adv)
            begin
                a_valid_reg   <= issue;
                b_valid_reg   <= a_valid_reg;
                c_valid_reg   <= b_valid_reg;
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Frame base hue.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            base_reg <= q_rd.hue;
        end
    end

    // Pipeline payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg      <= x_reg;
            a_y_reg      <= y_reg;
            a_last_reg   <= last_pix;
            a_hue_reg    <= hue_gen;
            b_x_reg      <= a_x_reg;
            b_y_reg      <= a_y_reg;
            b_last_reg   <= a_last_reg;
            b_sector_reg <= sector;
            b_frac_reg   <= frac;
            b_fprod_reg  <= fade_prod[32:16];
            c_x_reg      <= b_x_reg;
            c_y_reg      <= b_y_reg;
            c_last_reg   <= b_last_reg;
            c_r_reg      <= PROD_W'(brightness_level) * PROD_W'(lvl_r);
            c_g_reg      <= PROD_W'(brightness_level) * PROD_W'(lvl_g);
            c_b_reg      <= PROD_W'(brightness_level) * PROD_W'(lvl_b);
            out_x_reg    <= c_x_reg;
            out_y_reg    <= c_y_reg;
            out_last_reg <= c_last_reg;
            out_r_reg    <= ch_r;
            out_g_reg    <= ch_g;
            out_b_reg    <= ch_b;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign red        = out_r_reg;
    assign green      = out_g_reg;
    assign blue       = out_b_reg;
    assign frame_last = out_last_reg;

endmodule

FILE: rtl/rainbow_grid_color_generator_top.sv
// Tick words produce nothing. A render word passes the front stages and the
// queue to the color pipeline, then emits 64 pixels at one per cycle while
// out_stall is low. A frame occupies the pixel sequencer from its pop until its
// last pixel issues; a two-entry queue lets the front accept further words
// meanwhile. Reset clears the phase and all valid state and loads speed_gain
// with 1.0 and brightness_level with full brightness.
// ----------------------------------------------------------------------------
// rainbow_grid_color_generator_top
// Animated rainbow pattern for an 8x8 LED grid: phase ticks, frame renders.
// ----------------------------------------------------------------------------
module rainbow_grid_color_generator_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [rgcg_pkg::REG_INDEX_W-1:0] wr_index,
    input  logic [rgcg_pkg::REG_DATA_W-1:0]  wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [rgcg_pkg::DT_W-1:0]        delta_time,
    input  logic [rgcg_pkg::DYN_W-1:0]       dynamic_factor,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rgcg_pkg::COORD_W-1:0]     pixel_x,
    output logic [rgcg_pkg::COORD_W-1:0]     pixel_y,
    output logic [rgcg_pkg::CH_W-1:0]        red,
    output logic [rgcg_pkg::CH_W-1:0]        green,
    output logic [rgcg_pkg::CH_W-1:0]        blue,
    output logic                             frame_last
);

    logic [rgcg_pkg::SPEED_W-1:0]  speed_gain_reg;
    logic [rgcg_pkg::BRIGHT_W-1:0] brightness_reg;
    logic [rgcg_pkg::PHASE_W-1:0]  phase;
    rgcg_pkg::q_wr_t               q_wr;
    rgcg_pkg::q_rd_t               q_rd;
    logic                          q_full;
    logic                          pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg <= rgcg_pkg::SPEED_RESET;
            brightness_reg <= rgcg_pkg::BRIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rgcg_pkg::REG_SPEED_GAIN: speed_gain_reg <= wr_data;
                rgcg_pkg::REG_BRIGHTNESS: brightness_reg <= wr_data[rgcg_pkg::BRIGHT_W-1:0];
                default:                  speed_gain_reg <= speed_gain_reg;
            endcase
        end
    end

    // Front: phase accumulator and per-frame base hue.
    rgcg_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .delta_time     (delta_time),
        .dynamic_factor (dynamic_factor),
        .speed_gain     (speed_gain_reg),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .phase          (phase)
    );

    // Frame queue.
    rgcg_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .pop    (pop),
        .q_rd   (q_rd),
        .q_full (q_full)
    );

    // Back: pixel sequencer and color pipeline.
    rgcg_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_rd             (q_rd),
        .pop              (pop),
        .brightness_level (brightness_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .frame_last       (frame_last)
    );

    // The last pixel of a frame is always the bottom-right corner.
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |->
            pixel_x == rgcg_pkg::COORD_W'(rgcg_pkg::GRID_SIZE - 1) &&
            pixel_y == rgcg_pkg::COORD_W'(rgcg_pkg::GRID_SIZE - 1))
        else $error("frame_last away from the grid corner");

    // After a tick the phase stays within one turn.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == rgcg_pkg::OP_TICK |=> phase <= rgcg_pkg::TWO_PI_Q16)
        else $error("phase accumulator beyond two pi");

    // A queue pop only happens when an entry is present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_rd.valid && !(q_full && q_wr.valid))
        else $error("frame queue misuse");

endmodule

FILE: sim/tb_rainbow_grid_color_generator_top.sv
// ----------------------------------------------------------------------------
// tb_rainbow_grid_color_generator_top
// Self-checking bench for the rainbow grid generator. Tick and render words
// are driven over the valid/stall port. A pixel predictor keeps its own phase,
// speed gain and brightness, and works out the 64 pixels of every accepted
// render. Each pixel leaving the block is compared against the oldest
// prediction. Directed words cover phase wrap, field extremes and brightness
// above full. The random words run under three idling profiles, and one long
// output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_rainbow_grid_color_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int WORDS_PER_RUN = 28;

    // One predicted pixel.
    typedef struct packed {
        logic [rgcg_pkg::COORD_W-1:0] px;
        logic [rgcg_pkg::COORD_W-1:0] py;
        logic [rgcg_pkg::CH_W-1:0]    r;
        logic [rgcg_pkg::CH_W-1:0]    g;
        logic [rgcg_pkg::CH_W-1:0]    b;
        logic                         last;
    } pixel_t;

    // Pixel predictor: tracks phase and registers, holds the pixels still owed.
    class pixel_predictor;
        pixel_t                        owed_pixels[$];
        logic [rgcg_pkg::PHASE_W-1:0]  phase;
        logic [rgcg_pkg::SPEED_W-1:0]  speed;
        logic [rgcg_pkg::BRIGHT_W-1:0] bright;
        int                            errors;

        function void reset_state();
            phase  = '0;
            speed  = rgcg_pkg::SPEED_RESET;
            bright = rgcg_pkg::BRIGHT_RESET;
            errors = 0;
            owed_pixels.delete();
        endfunction

        function void set_reg(logic [rgcg_pkg::REG_INDEX_W-1:0] idx,
                              logic [rgcg_pkg::REG_DATA_W-1:0] data);
            if (idx == rgcg_pkg::REG_SPEED_GAIN)
                speed = data;
            else if (idx == rgcg_pkg::REG_BRIGHTNESS)
                bright = data[rgcg_pkg::BRIGHT_W-1:0];
        endfunction

        // The 1 - 0.8*t term of the sector blends.
        function longint unsigned fade(longint unsigned t);
            return longint'(rgcg_pkg::LEVEL_ONE)
                   - ((longint'(rgcg_pkg::EIGHT_TENTHS) * t) >> 16);
        endfunction

        // Scale a level to a 6-bit channel and saturate.
        function logic [rgcg_pkg::CH_W-1:0] channel(longint unsigned level);
            longint unsigned v;
            v = (longint'(bright) * level * longint'(rgcg_pkg::CH_MAX)) >> 24;
            return (v > rgcg_pkg::CH_MAX) ? rgcg_pkg::CH_MAX : v[rgcg_pkg::CH_W-1:0];
        endfunction

        function void note_word(logic o, logic [rgcg_pkg::DT_W-1:0] dt,
                                logic [rgcg_pkg::DYN_W-1:0] dyn);
            logic [rgcg_pkg::PHASE_W:0]  sum;
            longint unsigned             espeed;
            longint unsigned             base_hue;
            longint unsigned             lr, lg, lb;
            logic [rgcg_pkg::HUE_W-1:0]  hue;
            int unsigned                 h6;
            int unsigned                 sector;
            longint unsigned             frac;
            pixel_t                      p;
            if (o == rgcg_pkg::OP_TICK)
            begin
                // Advance the phase and wrap once past two pi.
                sum = phase + dt;
                if (sum[rgcg_pkg::PHASE_W-1:0] > rgcg_pkg::TWO_PI_Q16)
                    phase = sum[rgcg_pkg::PHASE_W-1:0] - rgcg_pkg::TWO_PI_Q16;
                else
                    phase = sum[rgcg_pkg::PHASE_W-1:0];
                return;
            end
            espeed   = longint'(speed) * (longint'(dyn) + 256);
            base_hue = (longint'(phase) * espeed) >> 20;
            for (int y = 0; y < rgcg_pkg::GRID_SIZE; y++)
            begin
                for (int x = 0; x < rgcg_pkg::GRID_SIZE; x++)
                begin
                    hue    = rgcg_pkg::HUE_W'(base_hue + longint'(x + y) * 8192);
                    h6     = int'(hue) * 6;
                    sector = h6 >> 16;
                    frac   = h6 & 32'hFFFF;
                    case (sector)
                        0:
                        begin
                            lr = rgcg_pkg::LEVEL_ONE;
                            lg = rgcg_pkg::LEVEL_FLOOR;
                            lb = fade(frac);
                        end
                        1:
                        begin
                            lr = fade(rgcg_pkg::LEVEL_ONE - frac);
                            lg = rgcg_pkg::LEVEL_ONE;
                            lb = rgcg_pkg::LEVEL_FLOOR;
                        end
                        2:
                        begin
                            lr = rgcg_pkg::LEVEL_FLOOR;
                            lg = rgcg_pkg::LEVEL_ONE;
                            lb = frac;
                        end
                        3:
                        begin
                            lr = fade(frac);
                            lg = rgcg_pkg::LEVEL_ONE;
                            lb = rgcg_pkg::LEVEL_FLOOR;
                        end
                        4:
                        begin
                            lr = rgcg_pkg::LEVEL_FLOOR;
                            lg = frac;
                            lb = rgcg_pkg::LEVEL_ONE;
                        end
                        default:
                        begin
                            lr = rgcg_pkg::LEVEL_ONE;
                            lg = rgcg_pkg::LEVEL_FLOOR;
                            lb = rgcg_pkg::LEVEL_ONE;
                        end
                    endcase
                    p.px   = x[rgcg_pkg::COORD_W-1:0];
                    p.py   = y[rgcg_pkg::COORD_W-1:0];
                    p.r    = channel(lr);
                    p.g    = channel(lg);
                    p.b    = channel(lb);
                    p.last = (x == rgcg_pkg::GRID_SIZE - 1) && (y == rgcg_pkg::GRID_SIZE - 1);
                    owed_pixels.push_back(p);
                end
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                             got.px, got.py, got.r, got.g, got.b, got.last);
                return;
            end
            want = owed_pixels.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("pixel mismatch: expected x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                             want.px, want.py, want.r, want.g, want.b, want.last);
                    $display("                got      x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                             got.px, got.py, got.r, got.g, got.b, got.last);
                end
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             wr_en = 1'b0;
    logic [rgcg_pkg::REG_INDEX_W-1:0] wr_index = '0;
    logic [rgcg_pkg::REG_DATA_W-1:0]  wr_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             op = rgcg_pkg::OP_TICK;
    logic [rgcg_pkg::DT_W-1:0]        delta_time = '0;
    logic [rgcg_pkg::DYN_W-1:0]       dynamic_factor = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [rgcg_pkg::COORD_W-1:0]     pixel_x;
    logic [rgcg_pkg::COORD_W-1:0]     pixel_y;
    logic [rgcg_pkg::CH_W-1:0]        red;
    logic [rgcg_pkg::CH_W-1:0]        green;
    logic [rgcg_pkg::CH_W-1:0]        blue;
    logic                             frame_last;

    pixel_predictor pred;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             pressure_armed = 1'b0;
    bit             pressure_done = 1'b0;
    int             hold_left = 0;
    int             cycles = 0;

    rainbow_grid_color_generator_top u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .delta_time     (delta_time),
        .dynamic_factor (dynamic_factor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .frame_last     (frame_last)
    );

    // Clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output stall: random idling, plus one long hold-off when armed.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (pressure_armed && !pressure_done)
        begin
            out_stall     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check every pixel word the block hands over.
    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.px   = pixel_x;
            got.py   = pixel_y;
            got.r    = red;
            got.g    = green;
            got.b    = blue;
            got.last = frame_last;
            pred.check_pixel(got);
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_word(input logic o, input logic [rgcg_pkg::DT_W-1:0] dt,
                             input logic [rgcg_pkg::DYN_W-1:0] dyn);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        delta_time     <= dt;
        dynamic_factor <= dyn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred.note_word(o, dt, dyn);
    endtask

    // A random word, biased toward field extremes.
    task automatic send_random_word(input int render_pct);
        logic                       o;
        logic [rgcg_pkg::DT_W-1:0]  dt;
        logic [rgcg_pkg::DYN_W-1:0] dyn;
        o = ($urandom_range(99) < render_pct) ? rgcg_pkg::OP_RENDER : rgcg_pkg::OP_TICK;
        case ($urandom_range(3))
            0: dt = '1;
            1: dt = rgcg_pkg::DT_W'($urandom_range(255));
            default: dt = rgcg_pkg::DT_W'($urandom);
        endcase
        case ($urandom_range(4))
            0: dyn = '1;
            1: dyn = '0;
            default: dyn = rgcg_pkg::DYN_W'($urandom);
        endcase
        send_word(o, dt, dyn);
    endtask

    // Drop valid and wait until every owed pixel has arrived and the block is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (pred.owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rgcg_pkg::REG_INDEX_W-1:0] idx,
                             input logic [rgcg_pkg::REG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        pred.set_reg(idx, data);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        pred = new();
        pred.reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: renders at zero phase with both factor extremes.
        send_idle_pct = 9;
        recv_idle_pct = 53;
        send_word(rgcg_pkg::OP_RENDER, rgcg_pkg::DT_W'($urandom), '0);
        send_word(rgcg_pkg::OP_RENDER, rgcg_pkg::DT_W'($urandom), '1);
        send_word(rgcg_pkg::OP_TICK, '0, rgcg_pkg::DYN_W'($urandom));
        // Full-size ticks, a render, then more full-size ticks until the phase wraps past two pi.
        repeat (3) send_word(rgcg_pkg::OP_TICK, '1, rgcg_pkg::DYN_W'($urandom));
        send_word(rgcg_pkg::OP_RENDER, rgcg_pkg::DT_W'($urandom), 10'd128);
        repeat (4) send_word(rgcg_pkg::OP_TICK, '1, rgcg_pkg::DYN_W'($urandom));
        send_word(rgcg_pkg::OP_RENDER, '1, '1);
        drain();

        // Brightness above full saturates the channels.
        write_reg(rgcg_pkg::REG_BRIGHTNESS, 16'd511);
        send_word(rgcg_pkg::OP_TICK, 16'd40000, '1);
        send_word(rgcg_pkg::OP_RENDER, '0, '0);
        drain();
        write_reg(rgcg_pkg::REG_BRIGHTNESS, 16'd0);
        send_word(rgcg_pkg::OP_RENDER, '0, 10'd300);
        drain();
        write_reg(rgcg_pkg::REG_SPEED_GAIN, 16'd0);
        write_reg(rgcg_pkg::REG_BRIGHTNESS, 16'd256);
        send_word(rgcg_pkg::OP_RENDER, '0, '1);
        drain();
        write_reg(rgcg_pkg::REG_SPEED_GAIN, 16'hFFFF);
        send_word(rgcg_pkg::OP_RENDER, '0, '1);
        send_word(rgcg_pkg::OP_TICK, 16'h0001, '0);
        send_word(rgcg_pkg::OP_RENDER, '0, '0);
        drain();

        // Random run one: sender idles rarely, receiver often.
        write_reg(rgcg_pkg::REG_SPEED_GAIN, rgcg_pkg::REG_DATA_W'($urandom));
        write_reg(rgcg_pkg::REG_BRIGHTNESS, rgcg_pkg::REG_DATA_W'($urandom_range(256)));
        repeat (WORDS_PER_RUN) send_random_word(45);
        drain();

        // Random run two: the other way round.
        send_idle_pct = 53;
        recv_idle_pct = 9;
        write_reg(rgcg_pkg::REG_SPEED_GAIN, 16'd4096);
        write_reg(rgcg_pkg::REG_BRIGHTNESS, rgcg_pkg::REG_DATA_W'($urandom_range(511)));
        repeat (WORDS_PER_RUN) send_random_word(45);
        drain();

        // Random run three: no idling, long output hold-off while renders pile up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(rgcg_pkg::REG_SPEED_GAIN, rgcg_pkg::REG_DATA_W'($urandom));
        write_reg(rgcg_pkg::REG_BRIGHTNESS, 16'd256);
        pressure_armed = 1'b1;
        repeat (6) send_random_word(100);
        repeat (WORDS_PER_RUN) send_random_word(45);
        drain();

        if (pred.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
